// ===== design/dfla_pkg.sv =====
// Shared types and constants for the descriptor free-list allocator.
`default_nettype none
package dfla_pkg;

   localparam int ADDR_W       = 64;
   localparam int KIND_W       = 2;
   localparam int HEAP_W       = 11;
   localparam int STRIDE_W     = 13;
   localparam int SLOT_W       = 10;
   localparam int STATUS_W     = 3;
   localparam int FREE_COUNT_W = 11;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = ADDR_W / DIV_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [HEAP_W-1:0]   HEAP_SIZE_RESET = 11'd1024;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 13'd32;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_MISMATCH = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_RANGE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_HEAP_SIZE = 2'd0,
      REG_CPU_BASE  = 2'd1,
      REG_GPU_BASE  = 2'd2,
      REG_STRIDE    = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_CHECK,
      S_READ,
      S_MUL,
      S_ADD,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       init;
      logic       finish_simple;
      status_type simple_status;
      logic       pop;
      logic       div_start;
      logic       free_check;
      logic       sel_idx;
      logic       mul;
      logic       add;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     count_zero;
      logic     stride_zero;
      logic     div_done;
      logic     out_busy;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// ===== design/dfla_div.sv =====
// Iterative 64-bit by 13-bit unsigned divider, four quotient bits per cycle.
`default_nettype none
module dfla_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dfla_pkg::ADDR_W-1:0]   dividend,
   input  wire logic [dfla_pkg::STRIDE_W-1:0] divisor,
   output logic      [dfla_pkg::ADDR_W-1:0]   quotient,
   output logic                               done
);
   import dfla_pkg::*;

   logic [ADDR_W-1:0]    work_ff, work_in;
   logic [STRIDE_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [STRIDE_W:0]   trial;
      logic [ADDR_W-1:0]   w;
      logic [STRIDE_W-1:0] r;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, w[ADDR_W-1]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            w = {w[ADDR_W-2:0], 1'b1};
         end else begin
            w = {w[ADDR_W-2:0], 1'b0};
         end
         r = trial[STRIDE_W-1:0];
      end
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = w;
         rem_in  = r;
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = work_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== design/dfla_ctrl.sv =====
// Sequencing state machine for the descriptor free-list allocator.
`default_nettype none
module dfla_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dfla_pkg::ctrl_stat_type stat,
   output dfla_pkg::ctrl_cmd_type       cmd
);
   import dfla_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (stat.kind)
               KIND_ALLOC: state_in = stat.count_zero ? S_DONE : S_READ;
               KIND_FREE:  state_in = stat.stride_zero ? S_DONE : S_DIV;
               default:    state_in = S_DONE;
            endcase
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_CHECK;
         end
         S_CHECK: state_in = S_DONE;
         S_READ:  state_in = S_MUL;
         S_MUL:   state_in = S_ADD;
         S_ADD:   state_in = S_DONE;
         S_DONE: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            case (stat.kind)
               KIND_INIT: begin
                  cmd.init          = 1'b1;
                  cmd.finish_simple = 1'b1;
                  cmd.simple_status = STATUS_OK;
               end
               KIND_ALLOC: begin
                  if (stat.count_zero) begin
                     cmd.finish_simple = 1'b1;
                     cmd.simple_status = STATUS_EMPTY;
                  end else begin
                     cmd.pop = 1'b1;
                  end
               end
               KIND_FREE: begin
                  if (stat.stride_zero) begin
                     cmd.finish_simple = 1'b1;
                     cmd.simple_status = STATUS_MISMATCH;
                  end else begin
                     cmd.div_start = 1'b1;
                  end
               end
               default: begin
                  cmd.finish_simple = 1'b1;
                  cmd.simple_status = STATUS_OK;
               end
            endcase
         end
         S_CHECK: cmd.free_check = 1'b1;
         S_READ:  cmd.sel_idx    = 1'b1;
         S_MUL:   cmd.mul        = 1'b1;
         S_ADD:   cmd.add        = 1'b1;
         S_DONE:  cmd.load_out   = !stat.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dfla_dp.sv =====
// Datapath: free-index stack, handle dividers, address arithmetic and result register.
`default_nettype none
module dfla_dp #(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dfla_pkg::ctrl_cmd_type            cmd,
   output dfla_pkg::ctrl_stat_type                stat,
   input  wire logic [dfla_pkg::HEAP_W-1:0]       heap_size,
   input  wire logic [dfla_pkg::ADDR_W-1:0]       cpu_base,
   input  wire logic [dfla_pkg::ADDR_W-1:0]       gpu_base,
   input  wire logic [dfla_pkg::STRIDE_W-1:0]     handle_stride,
   input  wire logic [dfla_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [dfla_pkg::ADDR_W-1:0]       req_cpu_handle,
   input  wire logic [dfla_pkg::ADDR_W-1:0]       req_gpu_handle,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [dfla_pkg::ADDR_W-1:0]       rsp_cpu_address,
   output logic      [dfla_pkg::ADDR_W-1:0]       rsp_gpu_address,
   output logic      [dfla_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic      [dfla_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [dfla_pkg::FREE_COUNT_W-1:0] rsp_free_count
);
   import dfla_pkg::*;

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int PROD_W = IDX_W + STRIDE_W;

   // Stack contents; entries below the low-water mark are not read from here, their init value is computed instead.
   logic [IDX_W-1:0] stack_mem [MAX_SLOTS];

   kind_type          kind_ff;
   logic [ADDR_W-1:0] cpu_handle_ff, gpu_handle_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lw_ff, lw_in;
   logic [CNT_W-1:0]  init_size_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic              use_init_ff;
   logic [IDX_W-1:0]  mem_q_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ADDR_W-1:0] res_cpu_ff, res_gpu_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   status_type        res_status_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_cpu_ff, rsp_gpu_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [FREE_COUNT_W-1:0] rsp_count_ff;

   logic [31:0]       size32;
   logic [CNT_W-1:0]  size;
   logic [CNT_W-1:0]  pop_pos;
   logic              use_init_in;
   logic [IDX_W-1:0]  init_val;
   logic [CNT_W-1:0]  init_val_wide;
   logic [31:0]       idx32;
   logic [31:0]       count32;
   logic [ADDR_W-1:0] qc, qg;
   logic              qc_done, qg_done;
   logic              q_match, q_in_range, has_room, push_ok;

   dfla_div u_div_cpu (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cpu_handle_ff - cpu_base),
      .divisor  (handle_stride),
      .quotient (qc),
      .done     (qc_done)
   );

   dfla_div u_div_gpu (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (gpu_handle_ff - gpu_base),
      .divisor  (handle_stride),
      .quotient (qg),
      .done     (qg_done)
   );

   always_comb begin
      size32        = (32'(heap_size) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : 32'(heap_size);
      size          = size32[CNT_W-1:0];
      pop_pos       = count_ff - CNT_W'(1);
      use_init_in   = pop_pos < lw_ff;
      init_val_wide = init_size_ff - CNT_W'(1) - CNT_W'(pos_ff);
      init_val      = init_val_wide[IDX_W-1:0];
      idx32         = 32'(idx_ff);
      count32       = 32'(count_ff);
      q_match       = qc == qg;
      q_in_range    = qc < ADDR_W'(size);
      has_room      = count_ff < size;
      push_ok       = q_match && q_in_range && has_room;

      stat.kind        = kind_ff;
      stat.count_zero  = count_ff == '0;
      stat.stride_zero = handle_stride == '0;
      stat.div_done    = qc_done && qg_done;
      stat.out_busy    = rsp_valid_ff && rsp_stall;

      count_in = count_ff;
      lw_in    = lw_ff;
      if (cmd.init) begin
         count_in = size;
         lw_in    = size;
      end else if (cmd.pop) begin
         count_in = pop_pos;
         if (use_init_in) lw_in = pop_pos;
      end else if (cmd.free_check && push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end

      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.free_check && push_ok) begin
         stack_mem[count_ff[IDX_W-1:0]] <= qc[IDX_W-1:0];
      end
      if (cmd.pop) begin
         mem_q_ff <= stack_mem[pop_pos[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff       <= kind_type'(req_kind);
         cpu_handle_ff <= req_cpu_handle;
         gpu_handle_ff <= req_gpu_handle;
      end
      if (cmd.init) init_size_ff <= size;
      if (cmd.pop) begin
         pos_ff      <= pop_pos[IDX_W-1:0];
         use_init_ff <= use_init_in;
      end
      if (cmd.sel_idx) idx_ff <= use_init_ff ? init_val : mem_q_ff;
      if (cmd.mul) prod_ff <= PROD_W'(idx_ff) * PROD_W'(handle_stride);
      if (cmd.finish_simple) begin
         res_cpu_ff    <= '0;
         res_gpu_ff    <= '0;
         res_slot_ff   <= '0;
         res_status_ff <= cmd.simple_status;
      end else if (cmd.add) begin
         res_cpu_ff    <= cpu_base + ADDR_W'(prod_ff);
         res_gpu_ff    <= gpu_base + ADDR_W'(prod_ff);
         res_slot_ff   <= idx32[SLOT_W-1:0];
         res_status_ff <= STATUS_OK;
      end else if (cmd.free_check) begin
         res_cpu_ff  <= '0;
         res_gpu_ff  <= '0;
         res_slot_ff <= '0;
         if (!q_match) begin
            res_status_ff <= STATUS_MISMATCH;
         end else if (!q_in_range) begin
            res_status_ff <= STATUS_RANGE;
         end else begin
            res_slot_ff   <= qc[SLOT_W-1:0];
            res_status_ff <= has_room ? STATUS_OK : STATUS_FULL;
         end
      end
      if (cmd.load_out) begin
         rsp_cpu_ff    <= res_cpu_ff;
         rsp_gpu_ff    <= res_gpu_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= count32[FREE_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cpu_address = rsp_cpu_ff;
   assign rsp_gpu_address = rsp_gpu_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_free_count  = rsp_count_ff;

endmodule
`default_nettype wire

// ===== design/descriptor_free_list_allocator_unit.sv =====
// Top level of the descriptor free-list allocator with its register port.
// Requests arrive on the req_ channel (valid/stall) with a kind code and two handles;
// each transaction produces exactly one transaction on the rsp_ channel.
// Kind init rebuilds the free stack, allocate pops an index and
// returns both addresses, free divides both handle offsets by the stride and pushes
// the index when the quotients agree and it fits.
// Init, unused kinds, an empty-list allocate and a zero-stride free finish in the
// execute state; allocate reads the stack, scales the index by the stride and adds
// the bases; free runs the 64-bit divider, which retires four quotient bits per cycle.
// One transaction is processed at a time; the next request is taken once the
// current result sits in the output register.
// When the receiver stalls, the result is held in the output register and the
// block finishes its next transaction up to the point of delivery, then waits.
// Reset empties the free list, loads the register defaults (1024 slots, zero bases,
// stride 32) and clears both channels; an init request is needed before allocating.
// Registers are 64 bits wide at byte addresses 0, 8, 16 and 24; the user must write
// them only while no transaction is in flight, which the block does not enforce.
`default_nettype none
module descriptor_free_list_allocator_unit #(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [dfla_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [dfla_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [dfla_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                      pready,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [dfla_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [dfla_pkg::ADDR_W-1:0]          req_cpu_handle,
   input  wire logic [dfla_pkg::ADDR_W-1:0]          req_gpu_handle,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [dfla_pkg::ADDR_W-1:0]          rsp_cpu_address,
   output logic      [dfla_pkg::ADDR_W-1:0]          rsp_gpu_address,
   output logic      [dfla_pkg::SLOT_W-1:0]          rsp_slot_index,
   output logic      [dfla_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [dfla_pkg::FREE_COUNT_W-1:0]    rsp_free_count
);
   import dfla_pkg::*;

   logic [HEAP_W-1:0]   heap_size_ff;
   logic [ADDR_W-1:0]   cpu_base_ff;
   logic [ADDR_W-1:0]   gpu_base_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic                csr_write;
   csr_reg_type         csr_sel;
   ctrl_cmd_type        cmd;
   ctrl_stat_type       stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = csr_reg_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_size_ff <= HEAP_SIZE_RESET;
         cpu_base_ff  <= '0;
         gpu_base_ff  <= '0;
         stride_ff    <= STRIDE_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            REG_HEAP_SIZE: heap_size_ff <= pwdata[HEAP_W-1:0];
            REG_CPU_BASE:  cpu_base_ff  <= pwdata;
            REG_GPU_BASE:  gpu_base_ff  <= pwdata;
            REG_STRIDE:    stride_ff    <= pwdata[STRIDE_W-1:0];
            default:       stride_ff    <= stride_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_HEAP_SIZE: prdata = CSR_DATA_W'(heap_size_ff);
         REG_CPU_BASE:  prdata = cpu_base_ff;
         REG_GPU_BASE:  prdata = gpu_base_ff;
         REG_STRIDE:    prdata = CSR_DATA_W'(stride_ff);
         default:       prdata = '0;
      endcase
   end

   dfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dfla_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .heap_size       (heap_size_ff),
      .cpu_base        (cpu_base_ff),
      .gpu_base        (gpu_base_ff),
      .handle_stride   (stride_ff),
      .req_kind        (req_kind),
      .req_cpu_handle  (req_cpu_handle),
      .req_gpu_handle  (req_gpu_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cpu_address (rsp_cpu_address),
      .rsp_gpu_address (rsp_gpu_address),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_status      (rsp_status),
      .rsp_free_count  (rsp_free_count)
   );

endmodule
`default_nettype wire

// ===== bench/descriptor_free_list_allocator_unit_tb.sv =====
// Self-checking testbench for the descriptor free-list allocator unit.
`default_nettype none
module descriptor_free_list_allocator_unit_tb;
   import dfla_pkg::*;

   localparam int SLOT_CAP       = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_ITEMS  = 250;

   typedef struct packed {
      logic [ADDR_W-1:0]       cpu_address;
      logic [ADDR_W-1:0]       gpu_address;
      logic [SLOT_W-1:0]       slot_index;
      status_type              status;
      logic [FREE_COUNT_W-1:0] free_count;
   } slot_result_type;

   typedef struct {
      logic              is_regs;
      kind_type          kind;
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] gpu;
      logic [HEAP_W-1:0] heap;
      logic [STRIDE_W-1:0] stride;
      logic              typed;
      slot_result_type   want;
   } plan_row_type;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;
   logic                    req_valid;
   logic                    req_stall;
   logic [KIND_W-1:0]       req_kind;
   logic [ADDR_W-1:0]       req_cpu_handle;
   logic [ADDR_W-1:0]       req_gpu_handle;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [ADDR_W-1:0]       rsp_cpu_address;
   logic [ADDR_W-1:0]       rsp_gpu_address;
   logic [SLOT_W-1:0]       rsp_slot_index;
   logic [STATUS_W-1:0]     rsp_status;
   logic [FREE_COUNT_W-1:0] rsp_free_count;

   logic [HEAP_W-1:0]       cfg_heap_size;
   logic [ADDR_W-1:0]       cfg_cpu_base;
   logic [ADDR_W-1:0]       cfg_gpu_base;
   logic [STRIDE_W-1:0]     cfg_stride;
   logic [SLOT_W-1:0]       slot_stack [SLOT_CAP];
   logic [FREE_COUNT_W-1:0] free_depth;

   slot_result_type         expected_results [$];
   slot_result_type         oldest_expected;
   plan_row_type            plan [$];
   logic [SLOT_W-1:0]       live_slots [$];
   int unsigned             mismatch_count;
   int unsigned             quiet_cycles;
   int                      sender_idle_pct;
   int                      receiver_idle_pct;

   descriptor_free_list_allocator_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_cpu_handle  (req_cpu_handle),
      .req_gpu_handle  (req_gpu_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cpu_address (rsp_cpu_address),
      .rsp_gpu_address (rsp_gpu_address),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_status      (rsp_status),
      .rsp_free_count  (rsp_free_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic slot_result_type predict_allocation(kind_type kind,
                                                          logic [ADDR_W-1:0] cpu_h,
                                                          logic [ADDR_W-1:0] gpu_h);
      slot_result_type   res;
      logic [HEAP_W-1:0] size;
      logic [ADDR_W-1:0] stride64;
      logic [ADDR_W-1:0] idx;
      logic [ADDR_W-1:0] qc;
      logic [ADDR_W-1:0] qg;
      int                i;
      res = '0;
      res.status = STATUS_OK;
      size = (cfg_heap_size > HEAP_W'(SLOT_CAP)) ? HEAP_W'(SLOT_CAP) : cfg_heap_size;
      stride64 = ADDR_W'(cfg_stride);
      case (kind)
         KIND_INIT: begin
            for (i = 0; i < int'(size); i++)
               slot_stack[i] = SLOT_W'(int'(size) - 1 - i);
            free_depth = size;
         end
         KIND_ALLOC: begin
            if (free_depth == 0 || free_depth > FREE_COUNT_W'(SLOT_CAP)) begin
               res.status = STATUS_EMPTY;
            end else begin
               free_depth = free_depth - 1'b1;
               idx = ADDR_W'(slot_stack[free_depth]);
               res.cpu_address = cfg_cpu_base + idx * stride64;
               res.gpu_address = cfg_gpu_base + idx * stride64;
               res.slot_index = idx[SLOT_W-1:0];
            end
         end
         KIND_FREE: begin
            if (stride64 == 0) begin
               res.status = STATUS_MISMATCH;
            end else begin
               qc = (cpu_h - cfg_cpu_base) / stride64;
               qg = (gpu_h - cfg_gpu_base) / stride64;
               if (qc != qg) begin
                  res.status = STATUS_MISMATCH;
               end else if (qc >= ADDR_W'(size)) begin
                  res.status = STATUS_RANGE;
               end else if (free_depth >= size) begin
                  res.status = STATUS_FULL;
                  res.slot_index = qc[SLOT_W-1:0];
               end else begin
                  slot_stack[free_depth] = qc[SLOT_W-1:0];
                  free_depth = free_depth + 1'b1;
                  res.slot_index = qc[SLOT_W-1:0];
               end
            end
         end
         default: ;
      endcase
      res.free_count = free_depth;
      return res;
   endfunction

   function automatic plan_row_type req_row(kind_type kind, logic [ADDR_W-1:0] cpu,
                                            logic [ADDR_W-1:0] gpu);
      plan_row_type row;
      row.is_regs = 1'b0;
      row.kind = kind;
      row.cpu = cpu;
      row.gpu = gpu;
      row.heap = '0;
      row.stride = '0;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic plan_row_type checked_row(kind_type kind, logic [ADDR_W-1:0] cpu,
                                                logic [ADDR_W-1:0] gpu,
                                                logic [SLOT_W-1:0] slot,
                                                status_type status,
                                                logic [FREE_COUNT_W-1:0] count);
      plan_row_type row;
      row = req_row(kind, cpu, gpu);
      row.typed = 1'b1;
      row.want.slot_index = slot;
      row.want.status = status;
      row.want.free_count = count;
      return row;
   endfunction

   function automatic plan_row_type regs_row(logic [HEAP_W-1:0] heap,
                                             logic [ADDR_W-1:0] cpu_b,
                                             logic [ADDR_W-1:0] gpu_b,
                                             logic [STRIDE_W-1:0] stride);
      plan_row_type row;
      row = req_row(KIND_NONE, cpu_b, gpu_b);
      row.is_regs = 1'b1;
      row.heap = heap;
      row.stride = stride;
      return row;
   endfunction

   function automatic logic [ADDR_W-1:0] random_base();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_row(input plan_row_type row);
      plan.insert(plan.size(), row);
   endtask

   task automatic issue_request(input kind_type kind, input logic [ADDR_W-1:0] cpu_h,
                                input logic [ADDR_W-1:0] gpu_h, input logic typed,
                                input slot_result_type typed_want,
                                output slot_result_type predicted);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_cpu_handle <= cpu_h;
      req_gpu_handle <= gpu_h;
      do @(posedge clock); while (req_stall);
      predicted = predict_allocation(kind, cpu_h, gpu_h);
      expected_results.insert(expected_results.size(), typed ? typed_want : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {which, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_HEAP_SIZE: cfg_heap_size = value[HEAP_W-1:0];
         REG_CPU_BASE:  cfg_cpu_base = value;
         REG_GPU_BASE:  cfg_gpu_base = value;
         REG_STRIDE:    cfg_stride = value[STRIDE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_regs(input logic [HEAP_W-1:0] heap, input logic [ADDR_W-1:0] cpu_b,
                             input logic [ADDR_W-1:0] gpu_b, input logic [STRIDE_W-1:0] stride);
      write_reg(REG_HEAP_SIZE, CSR_DATA_W'(heap));
      write_reg(REG_CPU_BASE, cpu_b);
      write_reg(REG_GPU_BASE, gpu_b);
      write_reg(REG_STRIDE, CSR_DATA_W'(stride));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transaction arrived with no request outstanding");
            mismatch_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            if (rsp_cpu_address !== oldest_expected.cpu_address) begin
               $error("cpu_address: expected %h, got %h",
                      oldest_expected.cpu_address, rsp_cpu_address);
               mismatch_count++;
            end
            if (rsp_gpu_address !== oldest_expected.gpu_address) begin
               $error("gpu_address: expected %h, got %h",
                      oldest_expected.gpu_address, rsp_gpu_address);
               mismatch_count++;
            end
            if (rsp_slot_index !== oldest_expected.slot_index) begin
               $error("slot_index: expected %0d, got %0d",
                      oldest_expected.slot_index, rsp_slot_index);
               mismatch_count++;
            end
            if (rsp_status !== oldest_expected.status) begin
               $error("status: expected %0d, got %0d", oldest_expected.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_free_count !== oldest_expected.free_count) begin
               $error("free_count: expected %0d, got %0d",
                      oldest_expected.free_count, rsp_free_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      slot_result_type   got;
      plan_row_type      row;
      logic [ADDR_W-1:0] idx;
      logic [ADDR_W-1:0] cpu_h;
      logic [ADDR_W-1:0] gpu_h;
      logic [ADDR_W-1:0] stride64;
      logic [HEAP_W-1:0] size;
      logic [HEAP_W-1:0] heap;
      logic [STRIDE_W-1:0] stride;
      kind_type          kind;
      int                pick;
      int                pos;
      int                seg;
      int                n;

      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_kind = KIND_ALLOC;
      req_cpu_handle = '0;
      req_gpu_handle = '0;
      rsp_stall = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      sender_idle_pct = 30;
      receiver_idle_pct = 68;
      cfg_heap_size = HEAP_SIZE_RESET;
      cfg_cpu_base = '0;
      cfg_gpu_base = '0;
      cfg_stride = STRIDE_RESET;
      free_depth = '0;

      add_row(checked_row(KIND_ALLOC, '0, '0, 10'd0, STATUS_EMPTY, 11'd0));
      add_row(checked_row(KIND_NONE, '1, '1, 10'd0, STATUS_OK, 11'd0));
      add_row(checked_row(KIND_FREE, '0, '0, 10'd0, STATUS_OK, 11'd1));
      add_row(checked_row(KIND_INIT, '0, '0, 10'd0, STATUS_OK, 11'd1024));
      add_row(checked_row(KIND_FREE, '0, '0, 10'd0, STATUS_FULL, 11'd1024));
      add_row(checked_row(KIND_ALLOC, '0, '0, 10'd0, STATUS_OK, 11'd1023));
      add_row(checked_row(KIND_FREE, 64'd32736, 64'd32767, 10'd1023, STATUS_OK, 11'd1024));
      add_row(checked_row(KIND_FREE, 64'd32, 64'd64, 10'd0, STATUS_MISMATCH, 11'd1024));
      add_row(checked_row(KIND_FREE, 64'd32768, 64'd32768, 10'd0, STATUS_RANGE, 11'd1024));
      add_row(regs_row(11'd2047, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000,
                       13'd4096));
      add_row(checked_row(KIND_INIT, '0, '0, 10'd0, STATUS_OK, 11'd1024));
      add_row(req_row(KIND_ALLOC, '0, '0));
      add_row(req_row(KIND_ALLOC, '0, '0));
      add_row(req_row(KIND_FREE, 64'h0000_0000_0000_0FF0, 64'h8000_0000_0000_1000));
      add_row(req_row(KIND_FREE, 64'h0000_0000_0000_0FF0, 64'h8000_0000_0000_1000));
      add_row(req_row(KIND_FREE, '1, '1));
      add_row(regs_row(11'd2047, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000,
                       13'd0));
      add_row(req_row(KIND_ALLOC, '0, '0));
      add_row(req_row(KIND_FREE, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000));
      add_row(regs_row(11'd0, '0, '0, 13'd1));
      add_row(checked_row(KIND_INIT, '0, '0, 10'd0, STATUS_OK, 11'd0));
      add_row(checked_row(KIND_FREE, '0, '0, 10'd0, STATUS_RANGE, 11'd0));
      add_row(checked_row(KIND_ALLOC, '0, '0, 10'd0, STATUS_EMPTY, 11'd0));
      add_row(regs_row(11'd8, '0, '0, 13'd1));
      add_row(checked_row(KIND_INIT, '0, '0, 10'd0, STATUS_OK, 11'd8));
      add_row(req_row(KIND_ALLOC, '0, '0));
      add_row(regs_row(11'd4, '0, '0, 13'd1));
      add_row(req_row(KIND_FREE, 64'd2, 64'd2));
      add_row(checked_row(KIND_NONE, '1, '0, 10'd0, STATUS_OK, 11'd7));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         row = plan[r];
         if (row.is_regs) begin
            wait_drained();
            write_regs(row.heap, row.cpu, row.gpu, row.stride);
         end else begin
            issue_request(row.kind, row.cpu, row.gpu, row.typed, row.want, got);
         end
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               sender_idle_pct = 30;
               receiver_idle_pct = 68;
            end
            1: begin
               sender_idle_pct = 68;
               receiver_idle_pct = 30;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         case (seg)
            0: begin
               heap = 11'd2047;
               stride = 13'd4096;
            end
            1: begin
               heap = 11'd1;
               stride = 13'd1;
            end
            2: begin
               heap = HEAP_W'($urandom_range(2, 16));
               stride = 13'd8191;
            end
            3: begin
               heap = 11'd1024;
               stride = STRIDE_W'($urandom_range(1, 4096));
            end
            4: begin
               heap = HEAP_W'($urandom_range(2, 40));
               stride = STRIDE_W'($urandom_range(1, 64));
            end
            default: begin
               heap = HEAP_W'($urandom_range(2, 64));
               stride = 13'd32;
            end
         endcase
         wait_drained();
         write_regs(heap, random_base(), random_base(), stride);
         size = (cfg_heap_size > HEAP_W'(SLOT_CAP)) ? HEAP_W'(SLOT_CAP) : cfg_heap_size;
         stride64 = ADDR_W'(cfg_stride);
         live_slots.delete();
         issue_request(KIND_INIT, '0, '0, 1'b0, '0, got);

         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            kind = KIND_FREE;
            cpu_h = {$urandom, $urandom};
            gpu_h = {$urandom, $urandom};
            if (live_slots.size() != 0) begin
               pos = $urandom_range(0, live_slots.size() - 1);
               idx = ADDR_W'(live_slots[pos]);
            end else begin
               pos = -1;
               idx = ADDR_W'($urandom_range(0, int'(size) - 1));
            end
            if (pick < 42) begin
               kind = KIND_ALLOC;
            end else if (pick < 82) begin
               if (pos >= 0 && $urandom_range(0, 99) >= 15)
                  live_slots.delete(pos);
               cpu_h = cfg_cpu_base + idx * stride64 +
                       ADDR_W'($urandom_range(0, int'(cfg_stride) - 1));
               gpu_h = cfg_gpu_base + idx * stride64 +
                       ADDR_W'($urandom_range(0, int'(cfg_stride) - 1));
            end else if (pick < 86) begin
               kind = KIND_INIT;
            end else if (pick < 89) begin
               kind = KIND_NONE;
            end else if (pick < 94) begin
               cpu_h = cfg_cpu_base + idx * stride64;
               gpu_h = cfg_gpu_base + (idx + 1 + ADDR_W'($urandom_range(0, 3))) * stride64;
            end else if (pick < 97) begin
               idx = ADDR_W'(size) + ADDR_W'($urandom_range(0, 3000));
               cpu_h = cfg_cpu_base + idx * stride64;
               gpu_h = cfg_gpu_base + idx * stride64;
            end
            issue_request(kind, cpu_h, gpu_h, 1'b0, '0, got);
            if (kind == KIND_INIT)
               live_slots.delete();
            else if (kind == KIND_ALLOC && got.status == STATUS_OK)
               live_slots.insert(live_slots.size(), got.slot_index);
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
